### hdl/dc_motor_speed_direction_control_macros.svh
// Assertion macros for the motor controller top level.
`ifndef DC_MOTOR_SPEED_DIRECTION_CONTROL_MACROS_SVH
`define DC_MOTOR_SPEED_DIRECTION_CONTROL_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge out of reset.
`define DCM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dcm: same-cycle check failed");
// Next-cycle implication.
`define DCM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dcm: next-cycle check failed");
`else
`define DCM_ASSERT_NOW(label, ante, cons)
`define DCM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### hdl/dcm_pkg.sv
// Types, constants and tables for the DC motor speed and direction controller.
package dcm_pkg;

  localparam int AdcBits   = 10;
  localparam int PwmBits   = 16;
  localparam int CntBits   = 4;
  localparam int StepBits  = 6;
  localparam int SpeedBits = 7;
  localparam int SpeedMax  = 100;
  localparam int AddrBits  = 4;
  localparam int DataBits  = 32;

  localparam logic [CntBits-1:0]   DebounceReset   = CntBits'(4);
  localparam logic [StepBits-1:0]  StepReset       = StepBits'(5);
  localparam logic [SpeedBits-1:0] StartSpeedReset = SpeedBits'(20);

  localparam logic [PwmBits-1:0] PwmFull = {PwmBits{1'b1}};
  localparam logic [AdcBits-1:0] AdcHalf = AdcBits'(1) << (AdcBits - 1);

  typedef enum logic [1:0] {
    REG_DEBOUNCE_TICKS = 2'd0,
    REG_SPEED_STEP     = 2'd1,
    REG_START_SPEED    = 2'd2,
    REG_UNUSED         = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [CntBits-1:0]   debounce_ticks;
    logic [StepBits-1:0]  speed_step;
    logic [SpeedBits-1:0] start_speed;
    logic                 speed_load;
  } cfg_t;

  typedef struct packed {
    logic inc;
    logic dec;
    logic cw;
    logic ccw;
  } btn_evt_t;

  typedef struct packed {
    logic               mode_button;
    logic               inc_button;
    logic               dec_button;
    logic               cw_button;
    logic               ccw_button;
    logic [AdcBits-1:0] adc_sample;
  } in_item_t;

  typedef struct packed {
    logic [PwmBits-1:0]   duty_a;
    logic [PwmBits-1:0]   duty_b;
    logic                 motor_enable;
    logic                 manual_mode;
    logic [SpeedBits-1:0] speed_percent;
    logic                 dir_clockwise;
  } result_t;

  typedef logic [PwmBits-1:0] duty_table_t [0:(1 << SpeedBits) - 1];

  // floor(speed * full / 100); entries above 100 are never addressed
  function automatic duty_table_t build_duty_table();
    duty_table_t t;
    for (int i = 0; i < (1 << SpeedBits); i++) begin
      if (i <= SpeedMax) begin
        t[i] = PwmBits'((i * ((1 << PwmBits) - 1)) / SpeedMax);
      end else begin
        t[i] = '0;
      end
    end
    return t;
  endfunction

  localparam duty_table_t ManualDuty = build_duty_table();

endpackage

### hdl/dcm_if.sv
// Valid/ready stream interfaces for the input and result channels.
interface dcm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode_button;
  logic                        inc_button;
  logic                        dec_button;
  logic                        cw_button;
  logic                        ccw_button;
  logic [dcm_pkg::AdcBits-1:0] adc_sample;

  modport source (output valid, mode_button, inc_button, dec_button, cw_button,
                  ccw_button, adc_sample, input ready);
  modport sink (input valid, mode_button, inc_button, dec_button, cw_button,
                ccw_button, adc_sample, output ready);
endinterface

interface dcm_out_if;
  logic                          valid;
  logic                          ready;
  logic [dcm_pkg::PwmBits-1:0]   duty_a;
  logic [dcm_pkg::PwmBits-1:0]   duty_b;
  logic                          motor_enable;
  logic                          manual_mode;
  logic [dcm_pkg::SpeedBits-1:0] speed_percent;
  logic                          dir_clockwise;

  modport source (output valid, duty_a, duty_b, motor_enable, manual_mode,
                  speed_percent, dir_clockwise, input ready);
  modport sink (input valid, duty_a, duty_b, motor_enable, manual_mode,
                speed_percent, dir_clockwise, output ready);
endinterface

### hdl/dcm_cfg.sv
// APB register block: debounce length, speed step and start speed.
module dcm_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dcm_pkg::AddrBits-1:0]  paddr,
  input  logic [dcm_pkg::DataBits-1:0]  pwdata,
  output logic [dcm_pkg::DataBits-1:0]  prdata,
  output logic                          pready,
  output dcm_pkg::cfg_t                 cfg_o
);
  import dcm_pkg::*;

  logic [CntBits-1:0]   ticks_q;
  logic [StepBits-1:0]  step_q;
  logic [SpeedBits-1:0] start_q;
  logic                 wr;
  reg_idx_e             idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= DebounceReset;
      step_q  <= StepReset;
      start_q <= StartSpeedReset;
    end else if (wr) begin
      unique case (idx)
        REG_DEBOUNCE_TICKS: ticks_q <= pwdata[CntBits-1:0];
        REG_SPEED_STEP:     step_q  <= pwdata[StepBits-1:0];
        REG_START_SPEED:    start_q <= pwdata[SpeedBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DEBOUNCE_TICKS: prdata = DataBits'(ticks_q);
      REG_SPEED_STEP:     prdata = DataBits'(step_q);
      REG_START_SPEED:    prdata = DataBits'(start_q);
      default:            prdata = '0;
    endcase
  end

  assign cfg_o.debounce_ticks = ticks_q;
  assign cfg_o.speed_step     = step_q;
  assign cfg_o.speed_load     = wr && (idx == REG_START_SPEED);
  // load value follows the bus so manual speed picks it up in the write cycle
  assign cfg_o.start_speed    = cfg_o.speed_load ? pwdata[SpeedBits-1:0] : start_q;

endmodule

### hdl/dcm_debounce.sv
// One button debouncer with a press event.
module dcm_debounce (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         level_i,
  input  logic [dcm_pkg::CntBits-1:0]  ticks_i,
  output logic                         event_o
);
  import dcm_pkg::*;

  logic [CntBits-1:0] cnt_q, cnt_d, cnt_inc, limit;
  logic               stable_q, stable_d;

  always_comb begin
    limit    = (ticks_i == '0) ? CntBits'(1) : ticks_i;
    cnt_inc  = (cnt_q == {CntBits{1'b1}}) ? cnt_q : cnt_q + CntBits'(1);
    cnt_d    = cnt_q;
    stable_d = stable_q;
    event_o  = 1'b0;
    if (en_i) begin
      if (level_i == stable_q) begin
        cnt_d = '0;
      end else if (cnt_inc >= limit) begin
        stable_d = level_i;
        cnt_d    = '0;
        event_o  = level_i;
      end else begin
        cnt_d = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      stable_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      stable_q <= stable_d;
    end
  end

endmodule

### hdl/dcm_core.sv
// Mode, speed, direction and duty state; its registers are the result register.
module dcm_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         advance_i,
  input  logic [dcm_pkg::AdcBits-1:0]  adc_i,
  input  logic                         mode_evt_i,
  input  dcm_pkg::btn_evt_t            btn_evt_i,
  input  dcm_pkg::cfg_t                cfg_i,
  output logic                         mode_next_o,
  output dcm_pkg::result_t             res_o
);
  import dcm_pkg::*;

  result_t res_q, res_d;

  logic [AdcBits+PwmBits-1:0]   prod_a;
  logic [AdcBits:0]             sum_b;
  logic [AdcBits+PwmBits:0]     prod_b;
  logic signed [SpeedBits+2:0]  speed_s;
  logic [SpeedBits-1:0]         speed_new;
  logic [SpeedBits-1:0]         start_sat;
  logic                         dir_new;

  assign mode_next_o = res_q.manual_mode ^ mode_evt_i;

  always_comb begin
    // adc * full and (2^adc_bits + 2*adc) * full as shift and subtract
    prod_a = {adc_i, {PwmBits{1'b0}}} - (AdcBits + PwmBits)'(adc_i);
    sum_b  = (AdcBits + 1)'(1 << AdcBits) + {adc_i, 1'b0};
    prod_b = {sum_b, {PwmBits{1'b0}}} - (AdcBits + PwmBits + 1)'(sum_b);

    speed_s = $signed({3'b000, res_q.speed_percent});
    if (btn_evt_i.inc) speed_s = speed_s + $signed({4'b0000, cfg_i.speed_step});
    if (btn_evt_i.dec) speed_s = speed_s - $signed({4'b0000, cfg_i.speed_step});
    if (speed_s > $signed((SpeedBits + 3)'(SpeedMax))) begin
      speed_new = SpeedBits'(SpeedMax);
    end else if (speed_s < 0) begin
      speed_new = '0;
    end else begin
      speed_new = speed_s[SpeedBits-1:0];
    end
    dir_new = res_q.dir_clockwise;
    if (btn_evt_i.cw)  dir_new = 1'b1;
    if (btn_evt_i.ccw) dir_new = 1'b0;

    start_sat = (cfg_i.start_speed > SpeedBits'(SpeedMax)) ? SpeedBits'(SpeedMax)
                                                          : cfg_i.start_speed;

    res_d = res_q;
    if (advance_i) begin
      res_d.manual_mode = mode_next_o;
      if (!mode_next_o) begin
        if (adc_i > AdcHalf) begin
          res_d.duty_a       = prod_a[AdcBits+PwmBits-1:AdcBits];
          res_d.duty_b       = '0;
          res_d.motor_enable = 1'b1;
        end else if (adc_i != '0 && adc_i < AdcHalf) begin
          res_d.duty_a       = '0;
          res_d.duty_b       = prod_b[AdcBits+PwmBits:AdcBits+1];
          res_d.motor_enable = 1'b1;
        end else begin
          res_d.motor_enable = 1'b0;
        end
      end else begin
        res_d.speed_percent = speed_new;
        res_d.dir_clockwise = dir_new;
        if (speed_new != '0) begin
          res_d.motor_enable = 1'b1;
          res_d.duty_a       = dir_new ? ManualDuty[speed_new] : '0;
          res_d.duty_b       = dir_new ? '0 : ManualDuty[speed_new];
        end else begin
          res_d.motor_enable = 1'b0;
        end
      end
    end else if (cfg_i.speed_load) begin
      res_d.speed_percent = start_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q.duty_a        <= '0;
      res_q.duty_b        <= '0;
      res_q.motor_enable  <= 1'b0;
      res_q.manual_mode   <= 1'b0;
      res_q.speed_percent <= StartSpeedReset;
      res_q.dir_clockwise <= 1'b1;
    end else begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

### hdl/dc_motor_speed_direction_control.sv
// Top level of the DC motor speed and direction controller.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+-------------------------------------------
//   in_if    | in  | valid/ready        | five raw button levels, adc_sample
//   out_if   | out | valid/ready        | duty_a, duty_b, enable, mode, speed, dir
//   apb      | in  | psel/penable/pready| three config registers at 0x0, 0x4, 0x8
//
// One item per clock sustained while each result is taken; an input transfer
// reaches the result through the input register, then the state/result register.
// The state registers double as the result register, so state advances only
// when the result slot is empty or being taken in the same cycle.
// A stalled result stalls the input register; in_if.ready drops only then.
// Reset clears all control state; no clearing pass is needed.
`include "dc_motor_speed_direction_control_macros.svh"

module dc_motor_speed_direction_control (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  dcm_in_if.sink                        in_if,
  dcm_out_if.source                     out_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dcm_pkg::AddrBits-1:0]  paddr,
  input  logic [dcm_pkg::DataBits-1:0]  pwdata,
  output logic [dcm_pkg::DataBits-1:0]  prdata,
  output logic                          pready
);
  import dcm_pkg::*;

  in_item_t s1_q;
  logic     s1_valid_q;
  logic     out_valid_q;
  logic     advance;
  logic     accept;
  logic     mode_evt;
  logic     mode_next;
  logic     manual_en;
  btn_evt_t btn_evt;
  cfg_t     cfg;
  result_t  res;

  assign advance     = s1_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !s1_valid_q || advance;
  assign accept      = in_if.valid && in_if.ready;
  assign manual_en   = advance && mode_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold payload; capture on transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.mode_button <= in_if.mode_button;
      s1_q.inc_button  <= in_if.inc_button;
      s1_q.dec_button  <= in_if.dec_button;
      s1_q.cw_button   <= in_if.cw_button;
      s1_q.ccw_button  <= in_if.ccw_button;
      s1_q.adc_sample  <= in_if.adc_sample;
    end
  end

  dcm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dcm_debounce u_db_mode (
    .clk_i, .rst_ni, .en_i(advance), .level_i(s1_q.mode_button),
    .ticks_i(cfg.debounce_ticks), .event_o(mode_evt)
  );
  dcm_debounce u_db_inc (
    .clk_i, .rst_ni, .en_i(manual_en), .level_i(s1_q.inc_button),
    .ticks_i(cfg.debounce_ticks), .event_o(btn_evt.inc)
  );
  dcm_debounce u_db_dec (
    .clk_i, .rst_ni, .en_i(manual_en), .level_i(s1_q.dec_button),
    .ticks_i(cfg.debounce_ticks), .event_o(btn_evt.dec)
  );
  dcm_debounce u_db_cw (
    .clk_i, .rst_ni, .en_i(manual_en), .level_i(s1_q.cw_button),
    .ticks_i(cfg.debounce_ticks), .event_o(btn_evt.cw)
  );
  dcm_debounce u_db_ccw (
    .clk_i, .rst_ni, .en_i(manual_en), .level_i(s1_q.ccw_button),
    .ticks_i(cfg.debounce_ticks), .event_o(btn_evt.ccw)
  );

  dcm_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .adc_i       (s1_q.adc_sample[AdcBits-1:0]),
    .mode_evt_i  (mode_evt),
    .btn_evt_i   (btn_evt),
    .cfg_i       (cfg),
    .mode_next_o (mode_next),
    .res_o       (res)
  );

  assign out_if.valid         = out_valid_q;
  assign out_if.duty_a        = res.duty_a;
  assign out_if.duty_b        = res.duty_b;
  assign out_if.motor_enable  = res.motor_enable;
  assign out_if.manual_mode   = res.manual_mode;
  assign out_if.speed_percent = res.speed_percent;
  assign out_if.dir_clockwise = res.dir_clockwise;

  `DCM_ASSERT_NOW(a_one_side_driven, res.motor_enable, (res.duty_a == '0 || res.duty_b == '0))
  `DCM_ASSERT_NOW(a_speed_in_range, 1'b1, (res.speed_percent <= SpeedBits'(SpeedMax)))
  `DCM_ASSERT_NEXT(a_mode_holds_when_idle, !advance, $stable(res.manual_mode))

endmodule

### tb/dc_motor_speed_direction_control_tb.sv
// Self-checking testbench for the DC motor speed and direction controller.
module dc_motor_speed_direction_control_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dcm_pkg::*;

  typedef enum int {
    BTN_MODE = 0,
    BTN_INC  = 1,
    BTN_DEC  = 2,
    BTN_CW   = 3,
    BTN_CCW  = 4
  } button_e;

  // raw button levels packed as {mode, inc, dec, cw, ccw}
  localparam logic [4:0] PressNone = 5'b00000;
  localparam logic [4:0] PressMode = 5'b10000;
  localparam logic [4:0] PressInc  = 5'b01000;
  localparam logic [4:0] PressDec  = 5'b00100;
  localparam logic [4:0] PressCw   = 5'b00010;
  localparam logic [4:0] PressCcw  = 5'b00001;

  localparam int unsigned FullScale  = PwmFull;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned MaxReports = 10;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [AddrBits-1:0] paddr   = '0;
  logic [DataBits-1:0] pwdata  = '0;
  logic [DataBits-1:0] prdata;
  logic                pready;

  dcm_in_if  in_bus ();
  dcm_out_if out_bus ();

  in_item_t drv_item    = '0;
  logic     drv_valid   = 1'b0;
  logic     rcv_ready   = 1'b0;

  assign in_bus.valid = drv_valid;
  assign {in_bus.mode_button, in_bus.inc_button, in_bus.dec_button, in_bus.cw_button,
          in_bus.ccw_button, in_bus.adc_sample} = drv_item;
  assign out_bus.ready = rcv_ready;

  dc_motor_speed_direction_control uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_bus),
    .out_if  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial forever #5 clk_i = ~clk_i;

  // Controller state mirrored by the predictor
  logic [CntBits-1:0]   cfg_debounce;
  logic [StepBits-1:0]  cfg_step;
  logic [SpeedBits-1:0] cfg_start;
  logic [CntBits-1:0]   btn_cnt [5];
  logic                 btn_stable [5];
  logic                 mode_manual;
  logic [SpeedBits-1:0] speed_pct;
  logic                 dir_cw;
  logic [PwmBits-1:0]   duty_a_q;
  logic [PwmBits-1:0]   duty_b_q;
  logic                 run_en;

  in_item_t    tick_q [$];
  result_t     pending_outputs_q [$];
  int unsigned ticks_queued = 0;
  int unsigned ticks_taken  = 0;
  int unsigned mismatches   = 0;
  int unsigned stall_cycles = 0;
  result_t     seen_res;
  result_t     want_res;

  task automatic reset_controller_model();
    cfg_debounce = DebounceReset;
    cfg_step     = StepReset;
    cfg_start    = StartSpeedReset;
    for (int i = 0; i < 5; i++) begin
      btn_cnt[i]    = '0;
      btn_stable[i] = 1'b0;
    end
    mode_manual = 1'b0;
    speed_pct   = StartSpeedReset;
    dir_cw      = 1'b1;
    duty_a_q    = '0;
    duty_b_q    = '0;
    run_en      = 1'b0;
  endtask

  // Returns 1 on the tick a button settles to pressed
  function automatic logic debounce(button_e idx, logic raw);
    logic [CntBits-1:0] need;
    need = (cfg_debounce == '0) ? CntBits'(1) : cfg_debounce;
    if (raw == btn_stable[idx]) begin
      btn_cnt[idx] = '0;
      return 1'b0;
    end
    if (btn_cnt[idx] != '1) btn_cnt[idx] = btn_cnt[idx] + 1'b1;
    if (btn_cnt[idx] >= need) begin
      btn_stable[idx] = raw;
      btn_cnt[idx]    = '0;
      return raw;
    end
    return 1'b0;
  endfunction

  function automatic result_t advance_controller(in_item_t t);
    logic        inc, dec, cw, ccw;
    int          spd;
    int unsigned adc, duty;
    if (debounce(BTN_MODE, t.mode_button)) mode_manual = ~mode_manual;
    if (!mode_manual) begin
      adc = t.adc_sample;
      if (adc > AdcHalf) begin
        duty_a_q = PwmBits'((adc * FullScale) >> AdcBits);
        duty_b_q = '0;
        run_en   = 1'b1;
      end else if (adc != 0 && adc < AdcHalf) begin
        duty_a_q = '0;
        duty_b_q = PwmBits'(((FullScale << AdcBits) + 2 * adc * FullScale) >> (AdcBits + 1));
        run_en   = 1'b1;
      end else begin
        run_en = 1'b0;
      end
    end else begin
      inc = debounce(BTN_INC, t.inc_button);
      dec = debounce(BTN_DEC, t.dec_button);
      cw  = debounce(BTN_CW, t.cw_button);
      ccw = debounce(BTN_CCW, t.ccw_button);
      spd = int'(speed_pct);
      if (inc) spd = spd + int'(cfg_step);
      if (dec) spd = spd - int'(cfg_step);
      // ccw applied last, so it wins over cw
      if (cw) dir_cw = 1'b1;
      if (ccw) dir_cw = 1'b0;
      if (spd > SpeedMax) spd = SpeedMax;
      else if (spd < 0) spd = 0;
      speed_pct = SpeedBits'(spd);
      if (speed_pct != '0) begin
        duty   = (int'(speed_pct) * FullScale) / SpeedMax;
        run_en = 1'b1;
        if (dir_cw) begin
          duty_a_q = PwmBits'(duty);
          duty_b_q = '0;
        end else begin
          duty_a_q = '0;
          duty_b_q = PwmBits'(duty);
        end
      end else begin
        run_en = 1'b0;
      end
    end
    return '{duty_a_q, duty_b_q, run_en, mode_manual, speed_pct, dir_cw};
  endfunction

  function automatic int unsigned idle_pct(bit sender);
    if (ticks_taken < 240) return sender ? 7 : 62;
    if (ticks_taken < 480) return sender ? 62 : 7;
    return 0;
  endfunction

  // Driver: present queued ticks, predict on every transfer
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && in_bus.ready) begin
        pending_outputs_q.push_back(advance_controller(drv_item));
        ticks_taken++;
      end
      if (!drv_valid || in_bus.ready) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
          drv_item  <= tick_q.pop_front();
          drv_valid <= 1'b1;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rcv_ready <= 1'b0;
    end else begin
      if (out_bus.valid && rcv_ready) begin
        seen_res = '{out_bus.duty_a, out_bus.duty_b, out_bus.motor_enable,
                     out_bus.manual_mode, out_bus.speed_percent, out_bus.dir_clockwise};
        if (pending_outputs_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t: result with no tick pending: a=%h b=%h en=%b man=%b spd=%0d cw=%b",
                     $realtime, seen_res.duty_a, seen_res.duty_b, seen_res.motor_enable,
                     seen_res.manual_mode, seen_res.speed_percent, seen_res.dir_clockwise);
        end else begin
          want_res = pending_outputs_q.pop_front();
          if (seen_res.duty_a !== want_res.duty_a || seen_res.duty_b !== want_res.duty_b ||
              seen_res.motor_enable !== want_res.motor_enable ||
              seen_res.manual_mode !== want_res.manual_mode ||
              seen_res.speed_percent !== want_res.speed_percent ||
              seen_res.dir_clockwise !== want_res.dir_clockwise) begin
            mismatches++;
            if (mismatches <= MaxReports) begin
              $display("%0t: want a=%h b=%h en=%b man=%b spd=%0d cw=%b", $realtime,
                       want_res.duty_a, want_res.duty_b, want_res.motor_enable,
                       want_res.manual_mode, want_res.speed_percent, want_res.dir_clockwise);
              $display("%0t: got  a=%h b=%h en=%b man=%b spd=%0d cw=%b", $realtime,
                       seen_res.duty_a, seen_res.duty_b, seen_res.motor_enable,
                       seen_res.manual_mode, seen_res.speed_percent, seen_res.dir_clockwise);
            end
          end
        end
      end
      rcv_ready <= ($urandom_range(99) >= idle_pct(1'b0));
    end
  end

  // Watchdog: count cycles without a transfer while work is outstanding
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((drv_valid && in_bus.ready) || (out_bus.valid && rcv_ready) ||
          (tick_q.size() == 0 && pending_outputs_q.size() == 0 && !drv_valid)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic cfg_write(reg_idx_e idx, logic [DataBits-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_DEBOUNCE_TICKS: cfg_debounce = value[CntBits-1:0];
      REG_SPEED_STEP:     cfg_step = value[StepBits-1:0];
      REG_START_SPEED: begin
        cfg_start = value[SpeedBits-1:0];
        speed_pct = (cfg_start > SpeedMax) ? SpeedBits'(SpeedMax) : cfg_start;
      end
      default: ;
    endcase
  endtask

  task automatic configure(int unsigned ticks, int unsigned step, int unsigned start);
    cfg_write(REG_DEBOUNCE_TICKS, DataBits'(ticks));
    cfg_write(REG_SPEED_STEP, DataBits'(step));
    cfg_write(REG_START_SPEED, DataBits'(start));
  endtask

  task automatic push_tick(logic [4:0] buttons, logic [AdcBits-1:0] adc);
    tick_q.push_back(in_item_t'({buttons, adc}));
    ticks_queued++;
  endtask

  function automatic logic [AdcBits-1:0] pick_adc();
    case ($urandom_range(15))
      0:       return '0;
      1:       return AdcBits'(1);
      2:       return AdcHalf - 1'b1;
      3:       return AdcHalf;
      4:       return AdcHalf + 1'b1;
      5:       return '1;
      default: return AdcBits'($urandom_range((1 << AdcBits) - 1));
    endcase
  endfunction

  // One press and release, sometimes too short to settle, or a burst of chatter
  task automatic add_gesture();
    int unsigned r, need, hold, rel;
    logic [4:0]  mask;
    need = (cfg_debounce == '0) ? 1 : cfg_debounce;
    r = $urandom_range(99);
    if (r < 12) begin
      repeat ($urandom_range(1, 4)) push_tick(5'($urandom_range(31)), pick_adc());
    end else begin
      if (r < 26) begin
        mask = PressMode;
      end else begin
        mask = PressInc >> $urandom_range(3);
        if ($urandom_range(3) == 0) mask = mask | (PressInc >> $urandom_range(3));
      end
      hold = need + $urandom_range(2);
      if ($urandom_range(6) == 0) hold = need - 1;
      rel = need + $urandom_range(2);
      repeat (hold) push_tick(mask, pick_adc());
      repeat (rel) push_tick(PressNone, pick_adc());
    end
  endtask

  task automatic fill_random(int unsigned count);
    int unsigned first;
    first = ticks_queued;
    while (ticks_queued - first < count) add_gesture();
  endtask

  // Hold off until every queued tick has produced its result
  task automatic wait_idle();
    while (ticks_taken != ticks_queued || pending_outputs_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    reset_controller_model();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero settle count acts as one tick; start above 100 saturates
    configure(0, 63, 127);
    push_tick(PressNone, '0);
    push_tick(PressNone, AdcBits'(1));
    push_tick(PressNone, AdcHalf - 1'b1);
    push_tick(PressNone, AdcHalf);
    push_tick(PressNone, AdcHalf + 1'b1);
    push_tick(PressNone, '1);
    push_tick(PressMode, AdcBits'(600));
    push_tick(PressNone, AdcBits'(700));
    push_tick(PressInc, '0);
    push_tick(PressNone, '0);
    push_tick(PressDec, '1);
    push_tick(PressNone, '1);
    push_tick(PressInc | PressDec, AdcHalf);
    push_tick(PressNone, AdcHalf);
    push_tick(PressCcw, AdcBits'(300));
    push_tick(PressNone, AdcBits'(300));
    push_tick(PressCw | PressCcw, AdcBits'(5));
    push_tick(PressNone, AdcBits'(5));
    push_tick(PressCw, AdcBits'(900));
    push_tick(PressNone, AdcBits'(900));
    push_tick(PressDec, AdcBits'(42));
    push_tick(PressNone, AdcBits'(42));
    push_tick(PressMode, AdcBits'(1000));
    push_tick(PressNone, AdcBits'(1000));
    fill_random(80);
    wait_idle();

    configure(4, 5, 20);
    fill_random(180);
    wait_idle();

    configure(15, 1, 0);
    cfg_write(REG_UNUSED, '1);
    fill_random(160);
    wait_idle();

    configure(2, 50, 100);
    fill_random(240);
    wait_idle();

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_outputs_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/dcm_pkg.sv
hdl/dcm_if.sv
hdl/dcm_cfg.sv
hdl/dcm_debounce.sv
hdl/dcm_core.sv
hdl/dc_motor_speed_direction_control.sv
tb/dc_motor_speed_direction_control_tb.sv
